// ----- src/nfe_pkg.sv -----
package nfe_pkg;

   // Frame constants
   localparam logic [7:0] START_RESET = 8'h21;
   localparam logic [7:0] CMD_READ    = 8'h70;
   localparam logic [7:0] CMD_WRITE   = 8'h60;
   localparam logic [7:0] CMD_PARAM   = 8'h6f;
   localparam logic [7:0] TAG_HDR     = 8'h90;
   localparam logic [7:0] TAG_DATA    = 8'h80;
   localparam logic [7:0] TAG_SUM_HI  = 8'ha0;
   localparam logic [7:0] TAG_SUM_LO  = 8'hb0;
   localparam logic [7:0] FRAME_TERM  = 8'hc0;
   localparam logic [7:0] NIB_MASK    = 8'h0f;

   // Item queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // Classified item, as the back end executes it
   typedef struct packed {
      logic       first;
      logic       last;
      logic       has_data;
      logic       param;
      logic [7:0] cmd;
      logic [7:0] address;
      logic [7:0] count;
      logic [7:0] data;
   } nfe_item_type;

   // Split a value into its high and low nibble bytes under a tag
   function automatic logic [7:0] nib_hi(input logic [7:0] tag, input logic [7:0] v);
      nib_hi = tag | ((v >> 4) & NIB_MASK);
   endfunction

   function automatic logic [7:0] nib_lo(input logic [7:0] tag, input logic [7:0] v);
      nib_lo = tag | (v & NIB_MASK);
   endfunction

endpackage

// ----- src/nfe_front.sv -----
module nfe_front
   import nfe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  logic         q_full,
   input  logic [1:0]   req_mode,
   input  logic         req_first,
   input  logic         req_last,
   input  logic [7:0]   req_address,
   input  logic [7:0]   req_count,
   input  logic         req_has_data,
   input  logic [7:0]   req_data_byte,
   output logic         q_push,
   output nfe_item_type q_item
);

   logic in_frame_ff;
   logic in_frame_in;
   logic accept;
   logic keep;

   // Classify the item: keep it only if it yields bytes
   always_comb begin
      accept = req_push && !q_full;
      keep   = req_first || (in_frame_ff && (req_has_data || req_last));
      q_push = accept && keep;

      q_item.first    = req_first;
      q_item.last     = req_last;
      q_item.has_data = req_has_data;
      q_item.param    = req_mode[1];
      if (req_mode[1]) begin
         q_item.cmd = CMD_PARAM;
      end else if (req_mode[0]) begin
         q_item.cmd = CMD_WRITE;
      end else begin
         q_item.cmd = CMD_READ;
      end
      q_item.address = req_address;
      q_item.count   = req_count;
      q_item.data    = req_data_byte;

      // Open on first, close on last
      in_frame_in = in_frame_ff;
      if (accept && (req_first || in_frame_ff)) begin
         in_frame_in = !req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
      end
   end

endmodule

// ----- src/nfe_queue.sv -----
module nfe_queue
   import nfe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  nfe_item_type push_item,
   input  logic         pop,
   output logic         full,
   output logic         empty,
   output nfe_item_type head
);

   nfe_item_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]      wr_ptr_ff;
   logic [QUEUE_AW-1:0]      rd_ptr_ff;
   logic [QUEUE_CW-1:0]      count_ff;
   logic                     do_push;
   logic                     do_pop;

   assign full    = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- src/nfe_back.sv -----
module nfe_back
   import nfe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write,
   input  logic [7:0]   csr_wdata,
   input  logic         q_empty,
   input  nfe_item_type head,
   output logic         q_pop,
   input  logic         rsp_pop,
   output logic         rsp_empty,
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_frame_end,
   output logic         rsp_run_last
);

   // Byte sequencer steps
   localparam logic [3:0] STEP_NONE  = 4'd0;
   localparam logic [3:0] STEP_START = 4'd1;
   localparam logic [3:0] STEP_CMD   = 4'd2;
   localparam logic [3:0] STEP_AH    = 4'd3;
   localparam logic [3:0] STEP_AL    = 4'd4;
   localparam logic [3:0] STEP_CH    = 4'd5;
   localparam logic [3:0] STEP_CL    = 4'd6;
   localparam logic [3:0] STEP_DH    = 4'd7;
   localparam logic [3:0] STEP_DL    = 4'd8;
   localparam logic [3:0] STEP_SH    = 4'd9;
   localparam logic [3:0] STEP_SL    = 4'd10;
   localparam logic [3:0] STEP_END   = 4'd11;

   logic [7:0] start_byte_ff;
   logic [3:0] step_ff;
   logic [3:0] step_in;
   logic [7:0] acc_ff;
   logic [7:0] acc_in;
   logic       out_valid_ff;
   logic [7:0] out_byte_ff;
   logic       out_end_ff;
   logic       out_last_ff;
   logic [3:0] cur_step;
   logic [3:0] next_step;
   logic [3:0] after_hdr;
   logic [3:0] after_data;
   logic [7:0] sum;
   logic [7:0] byte_val;
   logic       fire;

   always_comb begin
      after_data = head.last ? STEP_SH : STEP_NONE;
      after_hdr  = head.has_data ? STEP_DH : after_data;

      // Pick up a fresh item at its first byte
      if (step_ff == STEP_NONE) begin
         if (head.first) begin
            cur_step = STEP_START;
         end else begin
            cur_step = after_hdr;
         end
      end else begin
         cur_step = step_ff;
      end

      case (cur_step)
         STEP_START: next_step = STEP_CMD;
         STEP_CMD:   next_step = STEP_AH;
         STEP_AH:    next_step = STEP_AL;
         STEP_AL:    next_step = head.param ? STEP_CH : after_hdr;
         STEP_CH:    next_step = STEP_CL;
         STEP_CL:    next_step = after_hdr;
         STEP_DH:    next_step = STEP_DL;
         STEP_DL:    next_step = after_data;
         STEP_SH:    next_step = STEP_SL;
         STEP_SL:    next_step = STEP_END;
         default:    next_step = STEP_NONE;
      endcase

      sum = acc_ff ^ FRAME_TERM;
      case (cur_step)
         STEP_START: byte_val = start_byte_ff;
         STEP_CMD:   byte_val = head.cmd;
         STEP_AH:    byte_val = nib_hi(TAG_HDR, head.address);
         STEP_AL:    byte_val = nib_lo(TAG_HDR, head.address);
         STEP_CH:    byte_val = nib_hi(TAG_HDR, head.count);
         STEP_CL:    byte_val = nib_lo(TAG_HDR, head.count);
         STEP_DH:    byte_val = nib_hi(TAG_DATA, head.data);
         STEP_DL:    byte_val = nib_lo(TAG_DATA, head.data);
         STEP_SH:    byte_val = nib_hi(TAG_SUM_HI, sum);
         STEP_SL:    byte_val = nib_lo(TAG_SUM_LO, sum);
         default:    byte_val = FRAME_TERM;
      endcase

      // Emit one byte whenever an item is queued and the output slot frees up
      fire  = !q_empty && (!out_valid_ff || rsp_pop);
      q_pop = fire && (next_step == STEP_NONE);

      step_in = step_ff;
      acc_in  = acc_ff;
      if (fire) begin
         step_in = next_step;
         if (cur_step == STEP_START) begin
            acc_in = start_byte_ff;
         end else if (cur_step inside {[STEP_CMD:STEP_DL]}) begin
            acc_in = acc_ff ^ byte_val;
         end else if (cur_step == STEP_END) begin
            acc_in = '0;
         end
      end
   end

   // Hold the start byte register
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= START_RESET;
      end else if (csr_write) begin
         start_byte_ff <= csr_wdata;
      end
   end

   // Advance the sequencer and checksum
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_NONE;
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         acc_ff  <= acc_in;
         if (fire) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Load the output register on each transfer slot
   always_ff @(posedge clock) begin
      if (fire) begin
         out_byte_ff <= byte_val;
         out_end_ff  <= (cur_step == STEP_END);
         out_last_ff <= (next_step == STEP_NONE);
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_frame_end = out_end_ff;
   assign rsp_run_last  = out_last_ff;

endmodule

// ----- src/nibble_frame_encoder_unit.sv -----
// Channel   | Handshake             | Payload
// req_      | req_push / req_full   | mode, first, last, address, count, has_data, data_byte
// rsp_      | rsp_pop / rsp_empty   | out_byte, frame_end, run_last
// csr_      | csr_write             | csr_wdata (start byte)
//
// While not stalled, the back end emits one byte per cycle: a data item gives 2 bytes,
// an opening item 4 to 6 plus its data and trailer bytes, a closing trailer 3 bytes.
// A 4-entry item queue parts the front from the byte sequencer, so items keep
// arriving while bytes drain. Items that give no bytes are dropped at the front.
// Reset is synchronous and clears the queue, frame state and checksum.
module nibble_frame_encoder_unit
   import nfe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [1:0] req_mode,
   input  logic       req_first,
   input  logic       req_last,
   input  logic [7:0] req_address,
   input  logic [7:0] req_count,
   input  logic       req_has_data,
   input  logic [7:0] req_data_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_frame_end,
   output logic       rsp_run_last,
   input  logic       csr_write,
   input  logic [7:0] csr_wdata
);

   logic         q_push;
   logic         q_pop;
   logic         q_empty;
   nfe_item_type q_item;
   nfe_item_type q_head;

   nfe_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .q_full        (req_full),
      .req_mode      (req_mode),
      .req_first     (req_first),
      .req_last      (req_last),
      .req_address   (req_address),
      .req_count     (req_count),
      .req_has_data  (req_has_data),
      .req_data_byte (req_data_byte),
      .q_push        (q_push),
      .q_item        (q_item)
   );

   nfe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .pop       (q_pop),
      .full      (req_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   nfe_back u_back (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_wdata     (csr_wdata),
      .q_empty       (q_empty),
      .head          (q_head),
      .q_pop         (q_pop),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_frame_end (rsp_frame_end),
      .rsp_run_last  (rsp_run_last)
   );

endmodule

// ----- src/nfe_checker.sv -----
module nfe_checker
   import nfe_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_frame_end,
   input logic       rsp_run_last
);

   // A terminator is always the 0xC0 byte and closes its item
   a_end_byte: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_frame_end) |-> (rsp_out_byte == FRAME_TERM && rsp_run_last))
      else $error("frame end without terminator byte");

   // Reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending after reset");

   // Reset leaves room for input
   a_reset_room: assert property (@(posedge clock) reset |=> !req_full)
      else $error("queue full after reset");

   // A stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_out_byte)))
      else $error("stalled result changed");

endmodule

bind nibble_frame_encoder_unit nfe_checker u_nfe_checker (
   .clock         (clock),
   .reset         (reset),
   .req_full      (req_full),
   .rsp_empty     (rsp_empty),
   .rsp_pop       (rsp_pop),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_frame_end (rsp_frame_end),
   .rsp_run_last  (rsp_run_last)
);

// ----- sim/nfe_byte_stream_check.sv -----
`timescale 1ns / 1ps

// Stimulus-side codes shared by the stream check and the testbench top
package nfe_tb_pkg;

   typedef enum logic [1:0] {
      MODE_READ      = 2'd0,
      MODE_WRITE     = 2'd1,
      MODE_PARAM     = 2'd2,
      MODE_PARAM_ALT = 2'd3
   } frame_mode_type;

   typedef struct packed {
      frame_mode_type mode;
      logic           first;
      logic           last;
      logic [7:0]     address;
      logic [7:0]     count;
      logic           has_data;
      logic [7:0]     data_byte;
   } frame_item_type;

endpackage

module nfe_byte_stream_check
   import nfe_pkg::*;
   import nfe_tb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_full,
   input  logic [1:0] req_mode,
   input  logic       req_first,
   input  logic       req_last,
   input  logic [7:0] req_address,
   input  logic [7:0] req_count,
   input  logic       req_has_data,
   input  logic [7:0] req_data_byte,
   input  logic       rsp_empty,
   input  logic       rsp_pop,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_frame_end,
   input  logic       rsp_run_last,
   input  logic       csr_write,
   input  logic [7:0] csr_wdata,
   output int         fail_count,
   output int         pending_count
);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      logic       run_last;
   } frame_byte_type;

   // Bytes still owed by the block, oldest first
   frame_byte_type expected_bytes[$];

   // Own copy of the start byte and the frame state
   logic [7:0] start_byte;
   logic [7:0] frame_xor;
   logic       frame_open;

   task automatic push_frame_byte(input logic [7:0] b, input logic term, input logic fold);
      frame_byte_type e;
      e.out_byte  = b;
      e.frame_end = term;
      e.run_last  = 1'b0;
      expected_bytes.push_back(e);
      if (fold) begin
         frame_xor = frame_xor ^ b;
      end
   endtask

   task automatic push_nibble_pair(input logic [7:0] tag, input logic [7:0] v);
      push_frame_byte(tag | {4'h0, v[7:4]}, 1'b0, 1'b1);
      push_frame_byte(tag | {4'h0, v[3:0]}, 1'b0, 1'b1);
   endtask

   // Work out the bytes that one accepted item adds to the stream
   task automatic encode_frame_item(input frame_item_type it);
      int             base;
      logic [7:0]     cmd;
      logic [7:0]     sum;
      frame_byte_type tail;
      base = expected_bytes.size();
      if (it.first) begin
         frame_xor  = 8'h00;
         frame_open = 1'b1;
         case (it.mode)
            MODE_PARAM, MODE_PARAM_ALT: cmd = CMD_PARAM;
            MODE_WRITE:                 cmd = CMD_WRITE;
            default:                    cmd = CMD_READ;
         endcase
         push_frame_byte(start_byte, 1'b0, 1'b1);
         push_frame_byte(cmd, 1'b0, 1'b1);
         push_nibble_pair(TAG_HDR, it.address);
         // high mode bit selects the parameter block header
         if (it.mode[1]) begin
            push_nibble_pair(TAG_HDR, it.count);
         end
      end else if (!frame_open) begin
         return;
      end
      if (it.has_data) begin
         push_nibble_pair(TAG_DATA, it.data_byte);
      end
      if (it.last) begin
         sum = frame_xor ^ FRAME_TERM;
         push_frame_byte(TAG_SUM_HI | {4'h0, sum[7:4]}, 1'b0, 1'b0);
         push_frame_byte(TAG_SUM_LO | {4'h0, sum[3:0]}, 1'b0, 1'b0);
         push_frame_byte(FRAME_TERM, 1'b1, 1'b0);
         frame_xor  = 8'h00;
         frame_open = 1'b0;
      end
      // mark the final byte of this item
      if (expected_bytes.size() > base) begin
         tail = expected_bytes.pop_back();
         tail.run_last = 1'b1;
         expected_bytes.push_back(tail);
      end
   endtask

   // Watch all three ports at each edge; predict before compare
   always @(posedge clock) begin
      frame_item_type it;
      frame_byte_type want;
      if (reset) begin
         start_byte = START_RESET;
         frame_xor  = 8'h00;
         frame_open = 1'b0;
         fail_count = 0;
         expected_bytes.delete();
      end else begin
         if (csr_write) begin
            start_byte = csr_wdata;
         end
         if (req_push && !req_full) begin
            it.mode      = frame_mode_type'(req_mode);
            it.first     = req_first;
            it.last      = req_last;
            it.address   = req_address;
            it.count     = req_count;
            it.has_data  = req_has_data;
            it.data_byte = req_data_byte;
            encode_frame_item(it);
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_bytes.size() == 0) begin
               $display("%0t ns: unexpected transfer, expected none, got byte %02h %s %0b %0b",
                        $time, rsp_out_byte, "end/last", rsp_frame_end, rsp_run_last);
               fail_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (want.out_byte !== rsp_out_byte) begin
                  $display("%0t ns: out_byte expected %02h, got %02h",
                           $time, want.out_byte, rsp_out_byte);
                  fail_count++;
               end
               if (want.frame_end !== rsp_frame_end) begin
                  $display("%0t ns: frame_end expected %0b, got %0b (byte %02h)",
                           $time, want.frame_end, rsp_frame_end, want.out_byte);
                  fail_count++;
               end
               if (want.run_last !== rsp_run_last) begin
                  $display("%0t ns: run_last expected %0b, got %0b (byte %02h)",
                           $time, want.run_last, rsp_run_last, want.out_byte);
                  fail_count++;
               end
            end
         end
      end
      pending_count = expected_bytes.size();
   end

endmodule

// ----- sim/tb_nibble_frame_encoder_unit.sv -----
`timescale 1ns / 1ps

module tb_nibble_frame_encoder_unit;
   import nfe_pkg::*;
   import nfe_tb_pkg::*;

   localparam int    CLK_PERIOD   = 20;
   localparam int    DRAIN_CYCLES = 40;
   localparam int    PHASE_ITEMS  = 28;
   localparam longint SIM_LIMIT_NS = 64'd20_000_000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [1:0] req_mode = 2'd0;
   logic       req_first = 1'b0;
   logic       req_last = 1'b0;
   logic [7:0] req_address = 8'h00;
   logic [7:0] req_count = 8'h00;
   logic       req_has_data = 1'b0;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_frame_end;
   logic       rsp_run_last;
   logic       csr_write = 1'b0;
   logic [7:0] csr_wdata = 8'h00;
   int         fail_count;
   int         pending_count;

   // Stimulus bookkeeping
   bit         steady = 1'b0;
   bit         open_frame = 1'b0;
   int         useful_items = 0;
   int         pop_hold = 0;

   nibble_frame_encoder_unit uut (.*);

   nfe_byte_stream_check stream_check (.*);

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Idle length: mostly none or short, now and then long
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady) begin
         return 0;
      end
      if (r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic frame_item_type mk_item(input frame_mode_type mode, input logic first,
                                              input logic last, input logic [7:0] address,
                                              input logic [7:0] count, input logic has_data,
                                              input logic [7:0] data_byte);
      frame_item_type it;
      it.mode      = mode;
      it.first     = first;
      it.last      = last;
      it.address   = address;
      it.count     = count;
      it.has_data  = has_data;
      it.data_byte = data_byte;
      return it;
   endfunction

   function automatic frame_item_type random_item();
      return mk_item(frame_mode_type'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
                     8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
   endfunction

   // Drive one item and hold it until the transfer happens
   task automatic send_item(input frame_item_type it);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_mode      <= it.mode;
      req_first     <= it.first;
      req_last      <= it.last;
      req_address   <= it.address;
      req_count     <= it.count;
      req_has_data  <= it.has_data;
      req_data_byte <= it.data_byte;
      req_push      <= 1'b1;
      do @(posedge clock); while (req_full);
      if (it.first || open_frame) begin
         useful_items++;
      end
      open_frame = it.first ? !it.last : (open_frame && !it.last);
   endtask

   // Wait until every owed byte is out, then let queued silent items settle
   task automatic wait_drained();
      req_push <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_start_byte(input logic [7:0] v);
      wait_drained();
      csr_write <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // One frame with random content, now and then left open, or noise now and then
   task automatic random_frame();
      int             len;
      int             i;
      bit             broken;
      frame_item_type it;
      if ($urandom_range(0, 99) < 8) begin
         repeat ($urandom_range(1, 2)) begin
            it = random_item();
            it.first = 1'b0;
            send_item(it);
         end
         return;
      end
      len    = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 4) : $urandom_range(5, 10);
      broken = ($urandom_range(0, 9) == 0);
      for (i = 0; i < len; i++) begin
         it          = random_item();
         it.first    = (i == 0);
         it.last     = (i == len - 1) && !broken;
         it.has_data = ($urandom_range(0, 3) != 0);
         send_item(it);
      end
   endtask

   // Pull results with random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop  <= 1'b0;
         pop_hold <= 0;
      end else if (pop_hold > 0) begin
         rsp_pop  <= 1'b0;
         pop_hold <= pop_hold - 1;
      end else begin
         rsp_pop  <= 1'b1;
         pop_hold <= idle_gap();
      end
   end

   initial begin
      #(SIM_LIMIT_NS);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int phase;
      logic [7:0] start_value;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed items under the reset start byte
      // header and trailer only
      send_item(mk_item(MODE_READ,      1'b1, 1'b1, 8'h00, 8'h00, 1'b0, 8'h00));
      // count ignored
      send_item(mk_item(MODE_WRITE,     1'b1, 1'b0, 8'hff, 8'hff, 1'b1, 8'h00));
      // later address ignored
      send_item(mk_item(MODE_WRITE,     1'b0, 1'b0, 8'h3c, 8'h00, 1'b1, 8'hff));
      // in frame, no bytes
      send_item(mk_item(MODE_WRITE,     1'b0, 1'b0, 8'h00, 8'h11, 1'b0, 8'h55));
      send_item(mk_item(MODE_WRITE,     1'b0, 1'b1, 8'h77, 8'h00, 1'b1, 8'ha5));
      send_item(mk_item(MODE_PARAM,     1'b1, 1'b0, 8'h5a, 8'hff, 1'b0, 8'h00));
      send_item(mk_item(MODE_PARAM,     1'b0, 1'b1, 8'h00, 8'h00, 1'b1, 8'h0f));
      // mode three
      send_item(mk_item(MODE_PARAM_ALT, 1'b1, 1'b1, 8'hff, 8'h00, 1'b1, 8'hf0));
      // outside a frame
      send_item(mk_item(MODE_READ,      1'b0, 1'b1, 8'hff, 8'hff, 1'b1, 8'hff));
      send_item(mk_item(MODE_PARAM,     1'b0, 1'b0, 8'h12, 8'h34, 1'b1, 8'h56));
      // read with data
      send_item(mk_item(MODE_READ,      1'b1, 1'b0, 8'h81, 8'h42, 1'b1, 8'h7e));
      send_item(mk_item(MODE_READ,      1'b0, 1'b0, 8'h00, 8'h00, 1'b1, 8'h18));
      // abandons open frame
      send_item(mk_item(MODE_WRITE,     1'b1, 1'b0, 8'hc3, 8'h00, 1'b1, 8'h99));
      // restarts checksum
      send_item(mk_item(MODE_PARAM,     1'b1, 1'b1, 8'h00, 8'h80, 1'b1, 8'h01));
      send_item(mk_item(MODE_READ,      1'b1, 1'b0, 8'h24, 8'h00, 1'b0, 8'h00));
      // close without data
      send_item(mk_item(MODE_READ,      1'b0, 1'b1, 8'h00, 8'h00, 1'b0, 8'h00));

      // Random frames across start byte settings, extremes first
      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0:       start_value = 8'h00;
            1:       start_value = 8'hff;
            default: start_value = 8'($urandom);
         endcase
         set_start_byte(start_value);
         steady       = (phase == 2);
         useful_items = 0;
         while (useful_items < PHASE_ITEMS) begin
            random_frame();
         end
      end

      wait_drained();
      @(negedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
